// ===== rtl/core/shst_pkg.sv =====
// ----------------------------------------------------------------------------
// shst_pkg: shared types and constants for slope history health stats
// Widths of the record store, the accumulators and the iterative units.
// ----------------------------------------------------------------------------
package shst_pkg;

  localparam int HISTORY_DEPTH = 20;
  localparam int NSENS         = 3;
  localparam int SLOPE_W       = 32;
  localparam int ROW_W         = NSENS * SLOPE_W;
  localparam int AW            = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int SEL_W         = $clog2(NSENS);
  // |difference| of two slopes fits 32 bits unsigned
  localparam int MAG_W         = 32;
  localparam int SQ_W          = 2 * MAG_W;
  localparam int ACC_W         = SQ_W + $clog2(HISTORY_DEPTH);
  localparam int TOT_W         = ACC_W + CNT_W;
  localparam int DIV_W         = TOT_W;
  localparam int DVS_W         = (2 * CNT_W > MAG_W + 3) ? 2 * CNT_W : MAG_W + 3;
  localparam int DIV_CNT_W     = $clog2(DIV_W + 1);
  localparam int ROOT_W        = 31;

  typedef enum logic [1:0] {
    JOB_RATIO,
    JOB_ACCEL,
    JOB_SPREAD
  } job_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             start;
    logic [TOT_W-1:0] radicand;
  } sqrt_req_t;

endpackage

// ===== rtl/core/slope_history_health_stats_top.sv =====
// ----------------------------------------------------------------------------
// slope_history_health_stats_top: calibration history health metrics
// Stores a batch of records, then computes ratio, acceleration and spread.
// ----------------------------------------------------------------------------
// channel  | dir | content
// s_axis   | in  | one record: three slopes, tlast marks the oldest record
// m_axis   | out | one report per batch, tuser = report valid flag
//
// Records are taken one per cycle while loading. After the record with tlast
// the input stalls: a sweep over the store, then per sensor the setup and
// total states, up to three divisions on the shared divider and a square
// root. The report waits in the output register; loading of the next batch
// goes on. Reset clears the control state; the store needs no clearing.
// ----------------------------------------------------------------------------
module slope_history_health_stats_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slope_a [31:0], slope_b [63:32], slope_c [95:64]
  input  logic [95:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sample_total [4:0], ratio_a/b/c [36:5]/[68:37]/[100:69],
  // accel_a/b/c [132:101]/[164:133]/[196:165],
  // spread_a/b/c [227:197]/[258:228]/[289:259], zeros [295:290]
  output logic [295:0] m_axis_tdata,
  // report_valid [0]
  output logic [0:0]   m_axis_tuser
);
  import shst_pkg::*;

  localparam int FIELD_W = 5 + 6 * SLOPE_W + 3 * ROOT_W;
  localparam int OUT_W   = ((FIELD_W + 7) / 8) * 8;

  typedef enum logic [8:0] {
    ST_LOAD  = 9'b000000001,
    ST_SWEEP = 9'b000000010,
    ST_DRAIN = 9'b000000100,
    ST_SETUP = 9'b000001000,
    ST_TOTAL = 9'b000010000,
    ST_JOB   = 9'b000100000,
    ST_DIVW  = 9'b001000000,
    ST_SQRTW = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  function automatic logic signed [SLOPE_W-1:0] pick(input logic [ROW_W-1:0] row,
                                                     input logic [SEL_W-1:0] s);
    pick = row[s*SLOPE_W +: SLOPE_W];
  endfunction

  function automatic logic signed [SLOPE_W:0] diff33(input logic [SLOPE_W-1:0] a,
                                                     input logic [SLOPE_W-1:0] b);
    diff33 = {a[SLOPE_W-1], a} - {b[SLOPE_W-1], b};
  endfunction

  function automatic logic [MAG_W-1:0] mag32(input logic [SLOPE_W:0] x);
    logic [SLOPE_W:0] neg;
    neg   = -x;
    mag32 = x[SLOPE_W] ? neg[MAG_W-1:0] : x[MAG_W-1:0];
  endfunction

  function automatic logic [SLOPE_W-1:0] sat32(input logic [DIV_W-1:0] q, input logic neg);
    logic [SLOPE_W-1:0] nq;
    nq = ~q[SLOPE_W-1:0] + SLOPE_W'(1);
    if (neg) begin
      sat32 = ((|q[DIV_W-1:32]) || (q[31] && (|q[30:0]))) ? 32'h8000_0000 : nq;
    end else begin
      sat32 = (|q[DIV_W-1:31]) ? 32'h7FFF_FFFF : q[SLOPE_W-1:0];
    end
  endfunction

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic [1:0]         drain_q, drain_d;
  logic [SEL_W-1:0]   sel_q, sel_d;
  job_e               job_q, job_d;
  logic               rep_q, rep_d;
  logic               neg_q, neg_d;
  logic               rv_q, d_vld_q, sq_vld_q;
  logic [CNT_W-1:0]   ridx_q;
  logic               m_valid_q;
  logic [OUT_W-1:0]   m_data_q;
  logic               m_user_q;

  logic               in_acc, full, wr_en, rd_en, advance, res_we, out_load;
  logic [SLOPE_W-1:0] res_val;
  logic [ROW_W-1:0]   rd_data;
  div_req_t           div_req;
  sqrt_req_t          sqrt_req;
  logic               div_done, sqrt_done;
  logic [DIV_W-1:0]   quot;
  logic [ROOT_W-1:0]  root;

  logic [ROW_W-1:0]   prev_q, s0_q, s4_q, s5_q, sl_q;
  logic [MAG_W-1:0]   dmag_q [NSENS];
  logic [SQ_W-1:0]    sq_q   [NSENS];
  logic [ACC_W-1:0]   acc_q  [NSENS];
  logic [TOT_W-1:0]   prod_q, tot_q;
  logic [SQ_W-1:0]    sq1_q;
  logic [MAG_W+CNT_W-1:0] accn_q;
  logic [SLOPE_W-1:0] ratio_q  [NSENS];
  logic [SLOPE_W-1:0] accel_q  [NSENS];
  logic [ROOT_W-1:0]  spread_q [NSENS];

  logic signed [SLOPE_W-1:0] a0, a4, a5, al;
  logic signed [SLOPE_W:0]   d04, hist;
  logic [MAG_W-1:0]          hist_mag;
  logic [CNT_W-1:0]          m_cnt;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_LOAD);
  assign full          = (cnt_q == CNT_W'(HISTORY_DEPTH));
  assign m_cnt         = n_q - CNT_W'(1);

  always_comb begin
    a0       = pick(s0_q, sel_q);
    a4       = pick(s4_q, sel_q);
    a5       = pick(s5_q, sel_q);
    al       = pick(sl_q, sel_q);
    d04      = diff33(a0, a4);
    hist     = diff33(a5, al);
    hist_mag = mag32(hist);
  end

  shst_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[AW-1:0]),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  shst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  shst_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .done_o (sqrt_done),
    .root_o (root)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    rd_idx_d = rd_idx_q;
    drain_d  = drain_q;
    sel_d    = sel_q;
    job_d    = job_q;
    rep_d    = rep_q;
    neg_d    = neg_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    advance  = 1'b0;
    res_we   = 1'b0;
    res_val  = '0;
    out_load = 1'b0;
    div_req  = '0;
    sqrt_req = '0;

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (s_axis_tlast) begin
            n_d      = full ? cnt_q : cnt_q + CNT_W'(1);
            cnt_d    = '0;
            rd_idx_d = '0;
            sel_d    = '0;
            job_d    = JOB_RATIO;
            rep_d    = (n_d >= CNT_W'(2));
            state_d  = rep_d ? ST_SWEEP : ST_OUT;
          end
        end
      end
      ST_SWEEP: begin
        rd_en    = 1'b1;
        rd_idx_d = rd_idx_q + CNT_W'(1);
        if (rd_idx_q == m_cnt) begin
          drain_d = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == 2'd2) state_d = ST_SETUP;
      end
      ST_SETUP: state_d = ST_TOTAL;
      ST_TOTAL: state_d = ST_JOB;
      ST_JOB: begin
        unique case (job_q)
          JOB_RATIO: begin
            if (al <= 0) begin
              res_we  = 1'b1;
              advance = 1'b1;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = DIV_W'(mag32(diff33(a0, '0))) << 16;
              div_req.divisor  = DVS_W'(al);
              neg_d            = a0[SLOPE_W-1];
              state_d          = ST_DIVW;
            end
          end
          JOB_ACCEL: begin
            if ((n_q < CNT_W'(10)) || (hist == '0)) begin
              res_we  = 1'b1;
              advance = 1'b1;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = DIV_W'(accn_q) << 16;
              div_req.divisor  = (DVS_W'(hist_mag) << 2) + DVS_W'(hist_mag);
              neg_d            = d04[SLOPE_W] ^ hist[SLOPE_W];
              state_d          = ST_DIVW;
            end
          end
          JOB_SPREAD: begin
            if (n_q < CNT_W'(5)) begin
              res_we  = 1'b1;
              advance = 1'b1;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = tot_q;
              div_req.divisor  = DVS_W'(m_cnt) * (DVS_W'(m_cnt) - DVS_W'(1));
              neg_d            = 1'b0;
              state_d          = ST_DIVW;
            end
          end
          default: advance = 1'b1;
        endcase
      end
      ST_DIVW: begin
        if (div_done) begin
          if (job_q == JOB_SPREAD) begin
            sqrt_req.start    = 1'b1;
            sqrt_req.radicand = quot;
            state_d           = ST_SQRTW;
          end else begin
            res_we  = 1'b1;
            res_val = sat32(quot, neg_q);
            advance = 1'b1;
          end
        end
      end
      ST_SQRTW: begin
        if (sqrt_done) begin
          res_we  = 1'b1;
          res_val = SLOPE_W'(root);
          advance = 1'b1;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase

    if (advance) begin
      if (job_q == JOB_SPREAD) begin
        job_d = JOB_RATIO;
        if (sel_q == SEL_W'(NSENS - 1)) begin
          state_d = ST_OUT;
        end else begin
          sel_d   = sel_q + SEL_W'(1);
          state_d = ST_SETUP;
        end
      end else begin
        job_d   = (job_q == JOB_RATIO) ? JOB_ACCEL : JOB_SPREAD;
        state_d = ST_JOB;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      n_q       <= '0;
      rd_idx_q  <= '0;
      drain_q   <= '0;
      sel_q     <= '0;
      job_q     <= JOB_RATIO;
      rep_q     <= 1'b0;
      rv_q      <= 1'b0;
      ridx_q    <= '0;
      d_vld_q   <= 1'b0;
      sq_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      n_q      <= n_d;
      rd_idx_q <= rd_idx_d;
      drain_q  <= drain_d;
      sel_q    <= sel_d;
      job_q    <= job_d;
      rep_q    <= rep_d;
      rv_q     <= rd_en;
      ridx_q   <= rd_idx_q;
      d_vld_q  <= rv_q && (ridx_q != '0);
      sq_vld_q <= d_vld_q;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    if (rv_q) begin
      if (ridx_q == CNT_W'(0)) s0_q <= rd_data;
      if (ridx_q == CNT_W'(4)) s4_q <= rd_data;
      if (ridx_q == CNT_W'(5)) s5_q <= rd_data;
      if (ridx_q == m_cnt)     sl_q <= rd_data;
      prev_q <= rd_data;
    end
    for (int s = 0; s < NSENS; s++) begin
      // successive difference, then square, then accumulate
      dmag_q[s] <= mag32(diff33(pick(prev_q, SEL_W'(s)), pick(rd_data, SEL_W'(s))));
      sq_q[s]   <= dmag_q[s] * dmag_q[s];
      if (state_q == ST_LOAD) begin
        acc_q[s] <= '0;
      end else if (sq_vld_q) begin
        acc_q[s] <= acc_q[s] + ACC_W'(sq_q[s]);
      end
    end
    if (state_q == ST_SETUP) begin
      prod_q <= TOT_W'(acc_q[sel_q]) * TOT_W'(m_cnt);
      sq1_q  <= mag32(diff33(a0, al)) * mag32(diff33(a0, al));
      accn_q <= mag32(d04) * (n_q - CNT_W'(5));
    end
    if (state_q == ST_TOTAL) begin
      tot_q <= prod_q - TOT_W'(sq1_q);
    end
    if (res_we) begin
      case (job_q)
        JOB_RATIO:  ratio_q[sel_q]  <= res_val;
        JOB_ACCEL:  accel_q[sel_q]  <= res_val;
        default:    spread_q[sel_q] <= res_val[ROOT_W-1:0];
      endcase
    end
    if (out_load) begin
      m_user_q <= rep_q;
      if (rep_q) begin
        m_data_q <= {{(OUT_W-FIELD_W){1'b0}},
                     spread_q[2], spread_q[1], spread_q[0],
                     accel_q[2], accel_q[1], accel_q[0],
                     ratio_q[2], ratio_q[1], ratio_q[0],
                     5'(n_q)};
      end else begin
        m_data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

endmodule

// ===== rtl/core/shst_store.sv =====
// ----------------------------------------------------------------------------
// shst_store: calibration record memory
// One row holds the three slopes of a record; registered read port.
// ----------------------------------------------------------------------------
module shst_store (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [shst_pkg::AW-1:0]    wr_addr_i,
  input  logic [shst_pkg::ROW_W-1:0] wr_data_i,
  input  logic                     rd_en_i,
  input  logic [shst_pkg::AW-1:0]    rd_addr_i,
  output logic [shst_pkg::ROW_W-1:0] rd_data_o
);
  import shst_pkg::*;

  logic [ROW_W-1:0] mem_q [HISTORY_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== rtl/core/shst_div.sv =====
// ----------------------------------------------------------------------------
// shst_div: unsigned restoring divider
// One quotient bit per cycle, done is a pulse.
// ----------------------------------------------------------------------------
module shst_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  shst_pkg::div_req_t       req_i,
  output logic                     done_o,
  output logic [shst_pkg::DIV_W-1:0] quot_o
);
  import shst_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DVS_W:0]       rem_q;
  logic [DVS_W:0]       rem_sh;
  logic [DIV_W-1:0]     quo_q;
  logic [DVS_W-1:0]     dvs_q;
  logic                 qbit;

  always_comb begin
    rem_sh = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_q <= {quo_q[DIV_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/core/shst_sqrt.sv =====
// ----------------------------------------------------------------------------
// shst_sqrt: integer square root, result clamped to 31 bits
// Greedy bit setting from the top bit down, one bit per cycle.
// ----------------------------------------------------------------------------
module shst_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  shst_pkg::sqrt_req_t       req_i,
  output logic                      done_o,
  output logic [shst_pkg::ROOT_W-1:0] root_o
);
  import shst_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [ROOT_W-1:0]   mask_q;
  logic [ROOT_W-1:0]   root_q;
  logic [TOT_W-1:0]    rad_q;
  logic [ROOT_W-1:0]   trial;
  logic [2*ROOT_W-1:0] trial_sq;

  always_comb begin
    trial    = root_q | mask_q;
    trial_sq = trial * trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mask_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        mask_q <= {1'b1, {(ROOT_W-1){1'b0}}};
      end else if (busy_q) begin
        mask_q <= mask_q >> 1;
        if (mask_q[0]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      root_q <= '0;
      rad_q  <= req_i.radicand;
    end else if (busy_q && (TOT_W'(trial_sq) <= rad_q)) begin
      root_q <= trial;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for slope_history_health_stats_top
// Streams batches of calibration records, predicts each report from its own
// integer model of the ratio, acceleration and spread metrics, and compares
// every report field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import shst_pkg::*;

  localparam int DEPTH     = HISTORY_DEPTH;
  localparam int MAX_QUIET = 40000;

  typedef struct {
    logic [95:0] slopes;
    logic        last;
  } record_t;

  typedef struct {
    logic        valid;
    logic [4:0]  total;
    logic [31:0] ratio [3];
    logic [31:0] accel [3];
    logic [30:0] spread [3];
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [295:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  slope_history_health_stats_top DUT (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  record_t pending_records[$];
  report_t expected_reports[$];
  int mismatches = 0;
  int quiet_cycles = 0;

  // predictor state
  logic signed [31:0] batch_slopes [3][DEPTH];
  int batch_count = 0;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [30:0] spread_of(int s, int n);
    logic [127:0] sum_sq, tot, edge_sq, den, t, mg;
    logic [127:0] root;
    longint diff;
    int m;
    sum_sq = '0;
    root = '0;
    m = n - 1;
    for (int i = 0; i < m; i++) begin
      diff = longint'(batch_slopes[s][i]) - longint'(batch_slopes[s][i+1]);
      mg = (diff < 0) ? 128'(-diff) : 128'(diff);
      sum_sq += mg * mg;
    end
    diff = longint'(batch_slopes[s][0]) - longint'(batch_slopes[s][n-1]);
    mg = (diff < 0) ? 128'(-diff) : 128'(diff);
    edge_sq = mg * mg;
    tot = sum_sq * 128'(m) - edge_sq;
    den = 128'(m) * 128'(m - 1);
    for (int b = 30; b >= 0; b--) begin
      t = root | (128'd1 << b);
      if (t * t * den <= tot) root = t;
    end
    return root[30:0];
  endfunction

  task automatic predict_record(logic [95:0] slopes, logic last);
    report_t rep;
    longint first, hist, num;
    int n;
    if (batch_count < DEPTH) begin
      for (int s = 0; s < 3; s++) batch_slopes[s][batch_count] = slopes[32*s +: 32];
      batch_count++;
    end
    if (!last) return;
    n = batch_count;
    batch_count = 0;
    rep.valid = 1'b0;
    rep.total = '0;
    for (int s = 0; s < 3; s++) begin
      rep.ratio[s] = '0;
      rep.accel[s] = '0;
      rep.spread[s] = '0;
    end
    if (n >= 2) begin
      rep.valid = 1'b1;
      rep.total = 5'(n);
      for (int s = 0; s < 3; s++) begin
        first = batch_slopes[s][n-1];
        if (first > 0)
          rep.ratio[s] = 32'(sat32((longint'(batch_slopes[s][0]) * 65536) / first));
        if (n >= 10) begin
          hist = longint'(batch_slopes[s][5]) - first;
          if (hist != 0) begin
            num = (longint'(batch_slopes[s][0]) - longint'(batch_slopes[s][4]))
                  * longint'(n - 5) * 65536;
            rep.accel[s] = 32'(sat32(num / (hist * 5)));
          end
        end
        if (n >= 5) rep.spread[s] = spread_of(s, n);
      end
    end
    expected_reports.push_back(rep);
  endtask

  // ---------------- driver ----------------
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    record_t r;
    logic next_valid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_record(s_axis_tdata, s_axis_tlast);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_records.size() > 0) begin
          r = pending_records.pop_front();
          s_axis_tdata <= r.slopes;
          s_axis_tlast <= r.last;
          next_valid = 1'b1;
          send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // ---------------- monitor ----------------
  int recv_stall = 0;
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h actual %h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    report_t e;
    logic [31:0] act;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("report with no expectation: %h", m_axis_tdata);
        end else begin
          e = expected_reports.pop_front();
          check_field("report_valid", 32'(e.valid), 32'(m_axis_tuser[0]));
          check_field("sample_total", 32'(e.total), 32'(m_axis_tdata[4:0]));
          for (int s = 0; s < 3; s++) begin
            check_field($sformatf("ratio[%0d]", s), e.ratio[s], m_axis_tdata[5+32*s +: 32]);
            check_field($sformatf("accel[%0d]", s), e.accel[s],
                        m_axis_tdata[101+32*s +: 32]);
            act = 32'(m_axis_tdata[197+31*s +: 31]);
            check_field($sformatf("spread[%0d]", s), 32'(e.spread[s]), act);
          end
        end
        recv_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= MAX_QUIET) begin
      $display("tb failed");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [31:0] pick_slope(logic [31:0] base);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return base;
      default: return base + 32'($signed($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  task automatic add_record(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic last);
    record_t r;
    r.slopes = {c, b, a};
    r.last = last;
    pending_records.push_back(r);
  endtask

  initial begin
    int total_items, len;
    logic [31:0] base [3];
    logic [31:0] v [3];
    // single record: no valid report
    add_record(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b1);
    // two records, oldest negative, zero and positive
    add_record(32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_record(32'hffff_0000, 32'h0, 32'h0000_0001, 1'b1);
    // ten records: constant sensor a (zero deltas), extreme swings on b, a slow ramp on c
    for (int i = 0; i < 10; i++)
      add_record(32'h0002_0000, (i % 2) ? 32'h7fff_ffff : 32'h8000_0000,
                 32'h0001_0000 + 32'(i * 300), i == 9);
    total_items = 13;
    while (total_items < 1000) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, 4);
        1: len = $urandom_range(DEPTH + 1, DEPTH + 6);
        2: len = DEPTH;
        default: len = $urandom_range(5, DEPTH);
      endcase
      for (int s = 0; s < 3; s++)
        base[s] = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(1, 32'h0008_0000));
      for (int i = 0; i < len; i++) begin
        for (int s = 0; s < 3; s++) v[s] = pick_slope(base[s]);
        add_record(v[0], v[1], v[2], i == len - 1);
      end
      total_items += len;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_records.size() == 0 && !s_axis_tvalid && expected_reports.size() == 0);
    repeat (1500) @(posedge clk_i);
    if (expected_reports.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/shst_pkg.sv
rtl/core/shst_store.sv
rtl/core/shst_div.sv
rtl/core/shst_sqrt.sv
rtl/core/slope_history_health_stats_top.sv
test/tb.sv
